// File: hdl/multi_button_debounce_event_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce event encoder
// Clocked on clk; the gated form is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCE_EVENT_ENCODER_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_EVENT_ENCODER_ASSERT_SVH

// checked only out of reset
`define MBDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MBDE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mbde_pkg.sv
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared constants and types of the button debounce event encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mbde_pkg;

	localparam int NUM_BUTTONS = 5;
	localparam int EVT_W       = NUM_BUTTONS + 1;   // bit 0 heartbeat, bit i+1 button i
	localparam int CODE_W      = 8;
	localparam logic [CODE_W-1:0] HB_CODE = 8'hFE;

	localparam int DEB_W   = 16;
	localparam int GUARD_W = 16;
	localparam int HB_W    = 24;
	localparam int TIME_W  = 16;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_GUARD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT  = 2'd2;

	localparam logic [DEB_W-1:0]   DEB_RESET   = 16'd50;
	localparam logic [GUARD_W-1:0] GUARD_RESET = 16'd500;
	localparam logic [HB_W-1:0]    HB_RESET    = 24'd10000;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef logic [EVT_W-1:0] evt_mask_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// File: hdl/mbde_front.sv
// ----------------------------------------------------------------------------
// mbde_front
// Tick front end: counters, debounce per button, event mask per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mbde_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mbde_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [mbde_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic                               accept,
	input  wire logic [mbde_pkg::NUM_BUTTONS-1:0]   raw_buttons,
	output logic                                    q_push,
	output mbde_pkg::evt_mask_t                     q_mask
);
	import mbde_pkg::*;

	logic [DEB_W-1:0]       deb_q;
	logic [GUARD_W-1:0]     guard_q;
	logic [HB_W-1:0]        hb_ticks_q;
	logic [TIME_W-1:0]      time_q;
	logic [HB_W-1:0]        hb_q;
	logic [DEB_W-1:0]       settle_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] seen_q;
	logic [NUM_BUTTONS-1:0] conf_q;

	logic [TIME_W-1:0]      time_n;
	logic [HB_W-1:0]        hb_n;
	logic                   hb_fire;
	logic                   guard_open;
	logic [DEB_W-1:0]       settle_inc [NUM_BUTTONS];
	logic [DEB_W-1:0]       settle_nx  [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] commit;

	always_comb begin
		time_n     = (time_q == '1) ? time_q : time_q + 1'b1;
		hb_n       = (hb_q == '1) ? hb_q : hb_q + 1'b1;
		hb_fire    = (hb_n >= hb_ticks_q);
		guard_open = (time_n >= guard_q);
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			settle_inc[i] = (settle_q[i] == '1) ? settle_q[i] : settle_q[i] + 1'b1;
			if (guard_open) begin
				settle_nx[i] = (raw_buttons[i] != seen_q[i]) ? '0 : settle_inc[i];
				commit[i]    = (settle_nx[i] >= deb_q) && (raw_buttons[i] != conf_q[i]);
			end else begin
				settle_nx[i] = settle_inc[i];
				commit[i]    = 1'b0;
			end
		end
		q_mask = {commit & raw_buttons, hb_fire};
		q_push = accept && (q_mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q      <= DEB_RESET;
			guard_q    <= GUARD_RESET;
			hb_ticks_q <= HB_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEBOUNCE:   deb_q      <= cfg_wdata[DEB_W-1:0];
				REG_BOOT_GUARD: guard_q    <= cfg_wdata[GUARD_W-1:0];
				REG_HEARTBEAT:  hb_ticks_q <= cfg_wdata[HB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			hb_q   <= '0;
			seen_q <= '0;
			conf_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				settle_q[i] <= '0;
			end
		end else if (accept) begin
			time_q <= time_n;
			hb_q   <= hb_fire ? '0 : hb_n;
			if (guard_open) begin
				seen_q <= raw_buttons;
			end
			conf_q <= conf_q ^ commit;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				settle_q[i] <= settle_nx[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/mbde_queue.sv
// ----------------------------------------------------------------------------
// mbde_queue
// Short register queue of event masks between front end and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module mbde_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire mbde_pkg::evt_mask_t   wr_data,
	input  wire logic                  rd_en,
	output mbde_pkg::evt_mask_t        rd_data,
	output mbde_pkg::qstat_t           stat
);
	import mbde_pkg::*;

	evt_mask_t         mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/mbde_drain.sv
// ----------------------------------------------------------------------------
// mbde_drain
// Back end: takes one event mask, sends its events lowest bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module mbde_drain (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mbde_pkg::evt_mask_t           q_data,
	input  wire mbde_pkg::qstat_t              q_stat,
	output logic                               q_pop,
	input  wire logic                          pop,
	output logic                               empty,
	output logic [mbde_pkg::CODE_W-1:0]        event_code,
	output logic                               last_event
);
	import mbde_pkg::*;

	evt_mask_t         pend_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_last_q;

	logic              load_ok;
	logic              emit;
	evt_mask_t         low_bit;
	evt_mask_t         pend_after;
	logic [CODE_W-1:0] code;

	always_comb begin
		load_ok    = !out_valid_q || pop;
		emit       = load_ok && (pend_q != '0);
		low_bit    = pend_q & (~pend_q + 1'b1);
		pend_after = emit ? (pend_q & ~low_bit) : pend_q;
		q_pop      = (pend_after == '0) && !q_stat.empty;
		code       = low_bit[0] ? HB_CODE : '0;
		for (int i = 1; i < EVT_W; i++) begin
			code = code | (low_bit[i] ? CODE_W'(i - 1) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= q_pop ? q_data : pend_after;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_code_q <= code;
			out_last_q <= (pend_after == '0);
		end
	end

	assign empty      = !out_valid_q;
	assign event_code = out_code_q;
	assign last_event = out_last_q;

endmodule

`default_nettype wire

// File: hdl/multi_button_debounce_event_encoder.sv
// A tick's mask passes the mask queue and the drain's pending and result registers.
// Throughput: one tick beat per cycle while the 2-entry mask queue has room.
// The drain sends one result per cycle while pop is held, one tick's events at a time.
// Reset (arst_n low, async) restores register defaults, clears all counts and
// levels, empties the queue and the result register.
// ----------------------------------------------------------------------------
// multi_button_debounce_event_encoder
// Debounces button levels per tick and encodes press and heartbeat events.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_button_debounce_event_encoder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mbde_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [mbde_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [mbde_pkg::NUM_BUTTONS-1:0]   raw_buttons,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [mbde_pkg::CODE_W-1:0]             event_code,
	output logic                                    last_event
);
	import mbde_pkg::*;

	logic      accept;
	logic      q_push;
	evt_mask_t q_mask;
	logic      q_pop;
	evt_mask_t q_data;
	qstat_t    q_stat;

	assign full   = q_stat.full;
	assign accept = push && !full;

	mbde_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.raw_buttons (raw_buttons),
		.q_push      (q_push),
		.q_mask      (q_mask)
	);

	mbde_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_mask),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.stat    (q_stat)
	);

	mbde_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_data),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.event_code (event_code),
		.last_event (last_event)
	);

endmodule

`default_nettype wire

// File: hdl/mbde_checker.sv
// ----------------------------------------------------------------------------
// mbde_checker
// Port-level checks of the button debounce event encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_button_debounce_event_encoder_assert.svh"

module mbde_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mbde_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [mbde_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic                               push,
	input  wire logic                               full,
	input  wire logic [mbde_pkg::NUM_BUTTONS-1:0]   raw_buttons,
	input  wire logic                               empty,
	input  wire logic                               pop,
	input  wire logic [mbde_pkg::CODE_W-1:0]        event_code,
	input  wire logic                               last_event
);
	import mbde_pkg::*;

	`MBDE_ASSERT_RST(ast_reset_idle, !arst_n |-> (empty && !full), "not idle in reset")
	`MBDE_ASSERT(ast_code_range, !empty |-> (event_code == HB_CODE || event_code < CODE_W'(NUM_BUTTONS)), "bad event code")
	`MBDE_ASSERT(ast_hold, (!empty && !pop) |=> (!empty && $stable(event_code) && $stable(last_event)), "result changed while held")
	`MBDE_ASSERT(ast_tick_cont, (pop && !empty && !last_event) |=> (!empty && event_code != HB_CODE), "tick events broken")

endmodule

bind multi_button_debounce_event_encoder mbde_checker u_mbde_checker (.*);

`default_nettype wire

// File: verif/multi_button_debounce_event_encoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_button_debounce_event_encoder_checker
// Snoops the register port and both queue channels of the debounce event
// encoder, tracks the tick, heartbeat and settle counts per accepted tick,
// and compares every popped event against the oldest one still owed.
// ----------------------------------------------------------------------------

module multi_button_debounce_event_encoder_checker
	import mbde_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   push,
	input  logic                   full,
	input  logic [NUM_BUTTONS-1:0] raw_buttons,
	input  logic                   empty,
	input  logic                   pop,
	input  logic [CODE_W-1:0]      event_code,
	input  logic                   last_event,
	output int                     outstanding,
	output int                     errors
);

	typedef logic [NUM_BUTTONS-1:0] raw_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} press_event_t;

	press_event_t pending_events[$];

	logic [DEB_W-1:0]   deb_len;
	logic [GUARD_W-1:0] guard_len;
	logic [HB_W-1:0]    hb_len;

	raw_t               seen_lvl;
	raw_t               stable_lvl;
	logic [DEB_W-1:0]   settle [NUM_BUTTONS];
	logic [TIME_W-1:0]  tick_cnt;
	logic [HB_W-1:0]    hb_cnt;

	int fails = 0;

	assign errors = fails;

	task automatic flag_mismatch(input string what);
		$display("ERROR %0t ns: %s", $realtime, what);
		fails++;
	endtask

	task automatic debounce_tick(input raw_t raw);
		logic [CODE_W-1:0] codes [NUM_BUTTONS+1];
		press_event_t      ev;
		int                n;
		int                b;
		n = 0;
		if (tick_cnt != '1) tick_cnt++;
		if (hb_cnt != '1) hb_cnt++;
		for (b = 0; b < NUM_BUTTONS; b++) begin
			if (settle[b] != '1) settle[b]++;
		end
		if (hb_cnt >= hb_len) begin
			hb_cnt = '0;
			codes[n] = HB_CODE;
			n++;
		end
		if (tick_cnt >= guard_len) begin
			for (b = 0; b < NUM_BUTTONS; b++) begin
				if (raw[b] != seen_lvl[b]) begin
					seen_lvl[b] = raw[b];
					settle[b] = '0;
				end
				if (settle[b] >= deb_len && raw[b] != stable_lvl[b]) begin
					stable_lvl[b] = raw[b];
					if (raw[b]) begin
						codes[n] = CODE_W'(b);
						n++;
					end
				end
			end
		end
		for (b = 0; b < n; b++) begin
			ev.code = codes[b];
			ev.last = (b == n - 1);
			pending_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		press_event_t want;
		if (!arst_n) begin
			deb_len    = DEB_RESET;
			guard_len  = GUARD_RESET;
			hb_len     = HB_RESET;
			seen_lvl   = '0;
			stable_lvl = '0;
			for (int b = 0; b < NUM_BUTTONS; b++) settle[b] = '0;
			tick_cnt   = '0;
			hb_cnt     = '0;
			pending_events.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_DEBOUNCE:   deb_len   = cfg_wdata[DEB_W-1:0];
					REG_BOOT_GUARD: guard_len = cfg_wdata[GUARD_W-1:0];
					REG_HEARTBEAT:  hb_len    = cfg_wdata[HB_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_events.size() == 0) begin
					flag_mismatch($sformatf("event %0d popped with none owed", event_code));
				end else begin
					want = pending_events.pop_front();
					if (event_code !== want.code)
						flag_mismatch($sformatf("event_code %0d, want %0d",
							event_code, want.code));
					if (last_event !== want.last)
						flag_mismatch($sformatf("last_event %b, want %b (code %0d)",
							last_event, want.last, want.code));
				end
			end
			if (push && !full) debounce_tick(raw_buttons);
			outstanding <= pending_events.size();
		end
	end

endmodule

// File: verif/tb_multi_button_debounce_event_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_button_debounce_event_encoder
// Drives ticks of raw button levels through several register settings:
// reset defaults, all-zero lengths, fixed and random small lengths, and
// maximum lengths. Outside the steady runs, pushes and pops idle at
// random; the checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------

module tb_multi_button_debounce_event_encoder;
	import mbde_pkg::*;

	typedef logic [NUM_BUTTONS-1:0] raw_t;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx = REG_DEBOUNCE;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   push = 1'b0;
	logic                   full;
	raw_t                   raw_buttons = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [CODE_W-1:0]      event_code;
	logic                   last_event;

	int   outstanding;
	int   fails;
	bit   steady = 1'b0;
	raw_t walk = '0;

	multi_button_debounce_event_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.raw_buttons (raw_buttons),
		.empty       (empty),
		.pop         (pop),
		.event_code  (event_code),
		.last_event  (last_event)
	);

	multi_button_debounce_event_encoder_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.raw_buttons (raw_buttons),
		.empty       (empty),
		.pop         (pop),
		.event_code  (event_code),
		.last_event  (last_event),
		.outstanding (outstanding),
		.errors      (fails)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
	end

	initial begin
		#10_000_000;
		$display("multi_button_debounce_event_encoder: mismatch");
		$finish;
	end

	// upper data bits of the 16-bit registers are junk, the block masks them
	task automatic program_regs(input logic [DEB_W-1:0] deb, input logic [GUARD_W-1:0] guard,
			input logic [HB_W-1:0] hb);
		logic [CFG_W-1:0] wd;
		wd = CFG_W'($urandom);
		wd[DEB_W-1:0] = deb;
		cfg_we <= 1'b1;
		cfg_idx <= REG_DEBOUNCE;
		cfg_wdata <= wd;
		@(posedge clk);
		wd = CFG_W'($urandom);
		wd[GUARD_W-1:0] = guard;
		cfg_idx <= REG_BOOT_GUARD;
		cfg_wdata <= wd;
		@(posedge clk);
		cfg_idx <= REG_HEARTBEAT;
		cfg_wdata <= hb;
		@(posedge clk);
		cfg_idx <= REG_SPARE;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input raw_t val);
		while (!steady && $urandom_range(0, 99) < 32) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		raw_buttons <= val;
		do @(posedge clk); while (full);
	endtask

	// mostly held levels, some single-button flips, a little bounce noise
	function automatic raw_t next_raw(input raw_t cur);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return cur;
		if (r < 90) return cur ^ raw_t'(1 << $urandom_range(0, NUM_BUTTONS - 1));
		return raw_t'($urandom);
	endfunction

	task automatic run_ticks(input int n);
		repeat (n) begin
			walk = next_raw(walk);
			send_tick(walk);
		end
	endtask

	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		raw_t pattern [$];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: boot guard holds everything off
		pattern = '{5'b11111, 5'b00000, 5'b11111, 5'b01010};
		foreach (pattern[k]) send_tick(pattern[k]);
		drain();

		// zero lengths: heartbeat every tick, presses commit at once
		program_regs('0, '0, '0);
		pattern = '{5'b00000, 5'b11111, 5'b11111, 5'b00000, 5'b00001, 5'b00010,
			5'b00100, 5'b01000, 5'b10000, 5'b11111, 5'b10101, 5'b01010, 5'b00000, 5'b11111};
		foreach (pattern[k]) send_tick(pattern[k]);
		drain();

		program_regs(16'd3, 16'd30, 24'd7);
		run_ticks(120);
		drain();

		steady = 1'b1;
		program_regs(16'd1, '0, 24'd1);
		run_ticks(80);
		drain();
		steady = 1'b0;

		repeat (4) begin
			program_regs(DEB_W'($urandom_range(0, 6)), GUARD_W'($urandom_range(0, 400)),
				HB_W'($urandom_range(1, 25)));
			run_ticks(40);
			drain();
		end

		// max lengths: guard stays shut, heartbeat never due
		steady = 1'b1;
		program_regs('1, '1, '1);
		run_ticks(20);
		drain();
		steady = 1'b0;

		program_regs(16'd2, '1, 24'd5);
		run_ticks(60);

		drain();
		if (fails == 0)
			$display("multi_button_debounce_event_encoder: match");
		else
			$display("multi_button_debounce_event_encoder: mismatch");
		$finish;
	end

endmodule
